@@ design/rogu_pkg.sv @@
// Shared types and constants for the ray occupancy grid update block.
package rogu_pkg;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_CELL,
      ST_RMW,
      ST_REPORT,
      ST_RPT_WAIT,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic OP_RAY   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam int PERCENT = 100;
   localparam logic signed [7:0] BELIEF_UNKNOWN = -8'sd1;

endpackage

@@ design/rogu_ram.sv @@
// Generic single-port RAM with registered read.
module rogu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

@@ design/ray_occupancy_grid_update_top.sv @@
// Ray occupancy grid update: per-cell hit/miss counters with a Bresenham ray walk.
// Ray: per walked cell an address-and-read step and an update write, plus the setup,
//   report and done control states and a 1-bit-per-cycle serial belief divide.
// Query: the memory read and the same serial divide.
// One item at a time; busy stays high until the result strobe. Receiver cannot stall.
// After reset a clearing pass over all GRID_SIDE*GRID_SIDE cells zeroes both counter memories.
module ray_occupancy_grid_update_top
   import rogu_pkg::*;
#(
   parameter int GRID_SIDE   = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [7:0]         req_start_x,
   input  logic [7:0]         req_start_y,
   input  logic signed [9:0]  req_end_x,
   input  logic signed [9:0]  req_end_y,
   input  logic [7:0]         req_cell_x,
   input  logic [7:0]         req_cell_y,
   output logic               rsp_valid,
   output logic signed [7:0]  rsp_belief,
   output logic [15:0]        rsp_hit_count,
   output logic [15:0]        rsp_miss_count,
   output logic [10:0]        rsp_cells_walked,
   output logic               rsp_clipped
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = 14;
   localparam int PW    = COUNT_WIDTH + 7;
   localparam int DW    = COUNT_WIDTH + 1;
   localparam int NW    = $clog2(PW + 1);
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic signed [CW-1:0] p_ff, p_in, pb_ff, pb_in, q_ff, q_in;
   logic signed [CW-1:0] acc_ff, acc_in, span_ff, span_in, rise_ff, rise_in;
   logic signed [CW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic qneg_ff, qneg_in, ymaj_ff, ymaj_in, op_ff, op_in;
   logic hit_ff, hit_in, inside_ff, inside_in, clip_ff, clip_in;
   logic [10:0] walked_ff, walked_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [COUNT_WIDTH-1:0] h_ff, h_in, m_ff, m_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [DW:0] rem_ff, rem_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic valid_ff, valid_in;

   logic hit_we, miss_we;
   logic [COUNT_WIDTH-1:0] hit_wd, miss_wd, hit_rd, miss_rd;

   // memories see the next address so read data lines up with addr_ff
   rogu_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_hit_ram (
      .clock(clock), .wr_en(hit_we), .addr(addr_in), .wr_data(hit_wd), .rd_data(hit_rd)
   );
   rogu_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_miss_ram (
      .clock(clock), .wr_en(miss_we), .addr(addr_in), .wr_data(miss_wd), .rd_data(miss_rd)
   );

   function automatic logic signed [CW-1:0] sabs(input logic signed [CW-1:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic in_grid(input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
      return x >= 0 && y >= 0 && x < CW'(GRID_SIDE) && y < CW'(GRID_SIDE);
   endfunction

   logic signed [CW-1:0] sx, sy, ex, ey, dx, dy, cx, cy;
   logic signed [CW-1:0] acc_dec;
   logic [DW:0] rem_sh;
   logic [DW-1:0] divisor;
   logic [PW-1:0] prod;

   always_comb begin
      sx = CW'($signed({1'b0, req_start_x}));
      sy = CW'($signed({1'b0, req_start_y}));
      ex = CW'(req_end_x);
      ey = CW'(req_end_y);
      dx = sabs(ex - sx);
      dy = sabs(ey - sy);
      cx = ymaj_ff ? q_ff : p_ff;
      cy = ymaj_ff ? p_ff : q_ff;
      acc_dec = acc_ff - rise_ff;
      divisor = DW'(h_ff) + DW'(m_ff);
      prod = PW'(h_ff) * PW'(PERCENT);
      rem_sh = {rem_ff[DW-1:0], quo_ff[PW-1]};
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      p_in = p_ff; pb_in = pb_ff; q_in = q_ff; acc_in = acc_ff;
      span_in = span_ff; rise_in = rise_ff; ex_in = ex_ff; ey_in = ey_ff;
      qneg_in = qneg_ff; ymaj_in = ymaj_ff; op_in = op_ff;
      hit_in = hit_ff; inside_in = inside_ff; clip_in = clip_ff;
      walked_in = walked_ff; addr_in = addr_ff;
      h_in = h_ff; m_in = m_ff; quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      valid_in = 1'b0;
      hit_we = 1'b0; miss_we = 1'b0;
      hit_wd = '0; miss_wd = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            hit_we = 1'b1; miss_we = 1'b1;
            addr_in = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               op_in = req_op;
               walked_in = '0;
               clip_in = 1'b0;
               if (req_op == OP_QUERY) begin
                  ex_in = CW'($signed({1'b0, req_cell_x}));
                  ey_in = CW'($signed({1'b0, req_cell_y}));
                  state_in = ST_REPORT;
               end else begin
                  ex_in = ex; ey_in = ey;
                  ymaj_in = dy > dx;
                  if (dy > dx) begin
                     if (sy > ey) begin
                        p_in = ey; pb_in = sy; q_in = ex; qneg_in = sx < ex;
                     end else begin
                        p_in = sy; pb_in = ey; q_in = sx; qneg_in = ex < sx;
                     end
                     span_in = dy; rise_in = dx;
                  end else begin
                     if (sx > ex) begin
                        p_in = ex; pb_in = sx; q_in = ey; qneg_in = sy < ey;
                     end else begin
                        p_in = sx; pb_in = ex; q_in = sy; qneg_in = ey < sy;
                     end
                     span_in = dx; rise_in = dy;
                  end
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            acc_in = span_ff >>> 1;
            state_in = ST_CELL;
         end
         ST_CELL: begin
            walked_in = walked_ff + 11'd1;
            inside_in = in_grid(cx, cy);
            hit_in = (cx == ex_ff) && (cy == ey_ff);
            if (!in_grid(cx, cy)) clip_in = 1'b1;
            addr_in = AW'(cy) * AW'(GRID_SIDE) + AW'(cx);
            state_in = ST_RMW;
         end
         ST_RMW: begin
            // memory data for addr_ff is valid here
            if (inside_ff) begin
               if (hit_ff) begin
                  hit_we = 1'b1;
                  hit_wd = (hit_rd == CMAX) ? hit_rd : hit_rd + COUNT_WIDTH'(1);
               end else begin
                  miss_we = 1'b1;
                  miss_wd = (miss_rd == CMAX) ? miss_rd : miss_rd + COUNT_WIDTH'(1);
               end
            end
            p_in = p_ff + CW'(1);
            if (acc_dec < 0) begin
               q_in = qneg_ff ? q_ff - CW'(1) : q_ff + CW'(1);
               acc_in = acc_dec + span_ff;
            end else begin
               acc_in = acc_dec;
            end
            state_in = (p_ff == pb_ff) ? ST_REPORT : ST_CELL;
         end
         ST_REPORT: begin
            inside_in = in_grid(ex_ff, ey_ff);
            addr_in = AW'(ey_ff) * AW'(GRID_SIDE) + AW'(ex_ff);
            state_in = ST_RPT_WAIT;
         end
         ST_RPT_WAIT: begin
            h_in = inside_ff ? hit_rd : '0;
            m_in = inside_ff ? miss_rd : '0;
            rem_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) quo_in = prod;
            else begin
               // restoring divide, one quotient bit per cycle
               if (rem_sh >= {1'b0, divisor}) begin
                  rem_in = rem_sh - {1'b0, divisor};
                  quo_in = {quo_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[PW-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(PW)) state_in = ST_DONE;
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         addr_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         addr_ff <= addr_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in; pb_ff <= pb_in; q_ff <= q_in; acc_ff <= acc_in;
      span_ff <= span_in; rise_ff <= rise_in; ex_ff <= ex_in; ey_ff <= ey_in;
      qneg_ff <= qneg_in; ymaj_ff <= ymaj_in; op_ff <= op_in;
      hit_ff <= hit_in; inside_ff <= inside_in; clip_ff <= clip_in;
      walked_ff <= walked_in; h_ff <= h_in; m_ff <= m_in;
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_belief = (h_ff == '0 && m_ff == '0) ? BELIEF_UNKNOWN : $signed(quo_ff[7:0]);
   assign rsp_hit_count = 16'(h_ff);
   assign rsp_miss_count = 16'(m_ff);
   assign rsp_cells_walked = (op_ff == OP_QUERY) ? 11'd0 : walked_ff;
   assign rsp_clipped = (op_ff == OP_QUERY) ? 1'b0 : clip_ff;

`ifndef SYNTHESIS
   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !hit_we && !miss_we) else $error("memory write while idle");
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RMW |-> !(hit_we && miss_we)) else $error("both counters written");
`endif

endmodule
